// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is asserted
`define LPPD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked property that must also hold during reset
`define LPPD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/lppd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lppd_pkg;

    // header codes
    localparam logic [7:0] CODE_SHORT = 8'hC1;
    localparam logic [7:0] CODE_LONG  = 8'hC2;

    // header lengths counted in the total length
    localparam logic [15:0] HDR_SHORT = 16'd2;
    localparam logic [15:0] HDR_LONG  = 16'd3;

    // number of result slots in the output buffer
    localparam int unsigned OUT_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_CODE  = 3'd0,
        PH_LEN1  = 3'd1,
        PH_LENH  = 3'd2,
        PH_LENL  = 3'd3,
        PH_DATA  = 3'd4,
        PH_ERROR = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_of_packet;
        logic       last_of_packet;
        logic       empty_packet;
        logic       long_format;
        logic       header_error;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/length_prefixed_packet_deframer_top.sv -----
// result path: the result of an accepted word is registered into the result buffer that drives m_tvalid
// throughput: one word per cycle; s_tready drops only while both result slots are full
// the per-word state update is a single register stage, the result goes to a two-slot buffer
// reset: aresetn synchronous active low, returns to header code phase and empties the buffer
// a latched header error stays until reset, later words are taken and dropped
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_packet_deframer_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] payload_byte
    output logic            m_tlast,   // last_of_packet
    output logic [3:0]      m_tuser    // [0] first_of_packet, [1] empty_packet,
                                       // [2] long_format, [3] header_error
);
    import lppd_pkg::*;

    logic    in_accept;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_accept = s_tvalid && s_tready;

    // per-word header and payload tracking
    lppd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register with a spare slot
    lppd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // pack the result word
    assign m_tdata = out_res.payload_byte;
    assign m_tlast = out_res.last_of_packet;
    assign m_tuser = {out_res.header_error, out_res.long_format,
                      out_res.empty_packet, out_res.first_of_packet};

endmodule

`default_nettype wire

// ----- rtl/lppd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lppd_parser (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_accept,
    input  wire logic [7:0]       in_byte,
    output logic                  res_valid,
    output lppd_pkg::result_t     res
);
    import lppd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic        format_reg, format_next;
    logic        first_pending_reg, first_pending_next;

    logic [15:0] total;
    logic [15:0] hdr_len;
    logic        len_short;
    logic        len_empty;
    logic        data_last;

    // assembled total length and header size of the current packet
    assign total     = (phase_reg == PH_LEN1) ? {8'h00, in_byte} : {length_high_reg, in_byte};
    assign hdr_len   = format_reg ? HDR_LONG : HDR_SHORT;
    assign len_short = total < hdr_len;
    assign len_empty = total == hdr_len;
    assign data_last = remaining_reg <= 16'd1;

    // next state
    always_comb begin
        phase_next         = phase_reg;
        remaining_next     = remaining_reg;
        length_high_next   = length_high_reg;
        format_next        = format_reg;
        first_pending_next = first_pending_reg;
        if (in_accept) begin
            unique case (phase_reg) inside
                PH_CODE: begin
                    if (in_byte == CODE_SHORT) begin
                        format_next = 1'b0;
                        phase_next  = PH_LEN1;
                    end else if (in_byte == CODE_LONG) begin
                        format_next = 1'b1;
                        phase_next  = PH_LENH;
                    end else begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_LEN1, PH_LENL: begin
                    if (len_short) begin
                        phase_next = PH_ERROR;
                    end else if (len_empty) begin
                        phase_next = PH_CODE;
                    end else begin
                        remaining_next     = total - hdr_len;
                        first_pending_next = 1'b1;
                        phase_next         = PH_DATA;
                    end
                end
                PH_LENH: begin
                    length_high_next = in_byte;
                    phase_next       = PH_LENL;
                end
                PH_DATA: begin
                    first_pending_next = 1'b0;
                    if (remaining_reg != 16'd0) begin
                        remaining_next = remaining_reg - 16'd1;
                    end
                    if (data_last) begin
                        phase_next = PH_CODE;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // result for the accepted word
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        if (in_accept) begin
            unique case (phase_reg) inside
                PH_CODE: begin
                    if (in_byte != CODE_SHORT && in_byte != CODE_LONG) begin
                        res_valid        = 1'b1;
                        res.header_error = 1'b1;
                    end
                end
                PH_LEN1, PH_LENL: begin
                    res.long_format = format_reg;
                    if (len_short) begin
                        res_valid        = 1'b1;
                        res.header_error = 1'b1;
                    end else if (len_empty) begin
                        res_valid          = 1'b1;
                        res.empty_packet   = 1'b1;
                        res.last_of_packet = 1'b1;
                    end
                end
                PH_DATA: begin
                    res_valid           = 1'b1;
                    res.payload_byte    = in_byte;
                    res.first_of_packet = first_pending_reg;
                    res.last_of_packet  = data_last;
                    res.long_format     = format_reg;
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_CODE;
            remaining_reg     <= '0;
            length_high_reg   <= '0;
            format_reg        <= 1'b0;
            first_pending_reg <= 1'b0;
        end else begin
            phase_reg         <= phase_next;
            remaining_reg     <= remaining_next;
            length_high_reg   <= length_high_next;
            format_reg        <= format_next;
            first_pending_reg <= first_pending_next;
        end
    end

    // an error result always latches the error phase
    `LPPD_ASSERT(a_err_latch, aclk, aresetn, res_valid && res.header_error |=> phase_reg == PH_ERROR, "error result without latched error")
    // an empty packet always closes the packet
    `LPPD_ASSERT(a_empty_last, aclk, aresetn, res_valid && res.empty_packet |-> res.last_of_packet, "empty packet without last mark")
    // once latched, the error phase never gives a result
    `LPPD_ASSERT(a_err_quiet, aclk, aresetn, phase_reg == PH_ERROR |-> !res_valid, "result while error latched")

endmodule

`default_nettype wire

// ----- rtl/lppd_out_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lppd_out_buf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire lppd_pkg::result_t  in_res,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output lppd_pkg::result_t       out_res
);
    import lppd_pkg::*;

    localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
    localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

    result_t            slot_reg [OUT_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               pop;

    assign in_ready  = count_reg != CNT_W'(OUT_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_res   = slot_reg[rd_ptr_reg];
    assign push      = in_valid;
    assign pop       = out_valid && out_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result slots, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_res;
        end
    end

    // fill level stays within the slots
    `LPPD_ASSERT(a_count_range, aclk, aresetn, count_reg <= CNT_W'(OUT_DEPTH), "buffer overfilled")
    // a result is never written into a full buffer
    `LPPD_ASSERT(a_no_overflow, aclk, aresetn, push |-> in_ready, "push into full buffer")

endmodule

`default_nettype wire

// ----- tb/length_prefixed_packet_deframer_checker.sv -----
`timescale 1ns / 1ps

module length_prefixed_packet_deframer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // [7:0] payload_byte
    input  logic        m_tlast,    // last_of_packet
    input  logic [3:0]  m_tuser,    // [0] first_of_packet, [1] empty_packet,
                                    // [2] long_format, [3] header_error
    output int unsigned mismatches,
    output int unsigned pending,
    output int unsigned words_in,
    output int unsigned packets_done,
    output int unsigned empty_packets,
    output int unsigned payload_words,
    output int unsigned header_errors
);
    import lppd_pkg::*;

    // bit positions inside m_tuser
    localparam int TU_FIRST = 0;
    localparam int TU_EMPTY = 1;
    localparam int TU_LONG  = 2;
    localparam int TU_ERROR = 3;

    // deframer state, mirrors the block
    phase_t      frame_phase;
    logic [15:0] bytes_left;
    logic [7:0]  len_hi;
    logic        is_long;
    logic        first_due;

    result_t     framed_results[$];

    initial begin
        mismatches    = 0;
        pending       = 0;
        words_in      = 0;
        packets_done  = 0;
        empty_packets = 0;
        payload_words = 0;
        header_errors = 0;
    end

    // queue one expected result and keep the tallies
    task automatic expect_result(input result_t r);
        framed_results.push_back(r);
        if (r.last_of_packet) packets_done++;
        if (r.empty_packet) empty_packets++;
        if (r.header_error) header_errors++;
        if (!r.empty_packet && !r.header_error) payload_words++;
    endtask

    // a complete total length: error, empty packet or start of payload
    task automatic take_total(input logic [15:0] total);
        result_t     r;
        logic [15:0] hdr;
        r   = '0;
        hdr = is_long ? HDR_LONG : HDR_SHORT;
        r.long_format = is_long;
        if (total < hdr) begin
            frame_phase    = PH_ERROR;
            r.header_error = 1'b1;
            expect_result(r);
        end else if (total == hdr) begin
            frame_phase      = PH_CODE;
            r.empty_packet   = 1'b1;
            r.last_of_packet = 1'b1;
            expect_result(r);
        end else begin
            bytes_left  = total - hdr;
            first_due   = 1'b1;
            frame_phase = PH_DATA;
        end
    endtask

    // advance the deframer by one received word
    task automatic deframe_word(input logic [7:0] b);
        result_t r;
        r = '0;
        case (frame_phase)
            PH_CODE: begin
                if (b == CODE_SHORT) begin
                    is_long     = 1'b0;
                    frame_phase = PH_LEN1;
                end else if (b == CODE_LONG) begin
                    is_long     = 1'b1;
                    frame_phase = PH_LENH;
                end else begin
                    frame_phase    = PH_ERROR;
                    r.header_error = 1'b1;
                    expect_result(r);
                end
            end
            PH_LEN1: take_total({8'h00, b});
            PH_LENH: begin
                len_hi      = b;
                frame_phase = PH_LENL;
            end
            PH_LENL: take_total({len_hi, b});
            PH_DATA: begin
                r.payload_byte    = b;
                r.first_of_packet = first_due;
                r.last_of_packet  = (bytes_left <= 16'd1);
                r.long_format     = is_long;
                first_due = 1'b0;
                if (bytes_left > 16'd0) bytes_left = bytes_left - 16'd1;
                if (r.last_of_packet) frame_phase = PH_CODE;
                expect_result(r);
            end
            default: ;  // latched error, words are dropped
        endcase
    endtask

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endfunction

    // predict on accepted input words, compare on accepted results
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            frame_phase = PH_CODE;
            bytes_left  = '0;
            len_hi      = '0;
            is_long     = 1'b0;
            first_due   = 1'b0;
            framed_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                words_in++;
                deframe_word(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (framed_results.size() == 0) begin
                    $error("unexpected result word: payload_byte %0h tlast %0b tuser %0h",
                           m_tdata, m_tlast, m_tuser);
                    mismatches++;
                end else begin
                    want = framed_results.pop_front();
                    check_field("payload_byte", want.payload_byte, m_tdata);
                    check_field("first_of_packet", want.first_of_packet, m_tuser[TU_FIRST]);
                    check_field("last_of_packet", want.last_of_packet, m_tlast);
                    check_field("empty_packet", want.empty_packet, m_tuser[TU_EMPTY]);
                    check_field("long_format", want.long_format, m_tuser[TU_LONG]);
                    check_field("header_error", want.header_error, m_tuser[TU_ERROR]);
                end
            end
        end
        pending = framed_results.size();
    end

endmodule

// ----- tb/length_prefixed_packet_deframer_top_test.sv -----
`timescale 1ns / 1ps

module length_prefixed_packet_deframer_top_test;
    import lppd_pkg::*;

    // codes that are reserved and must raise a header error
    localparam logic [7:0] CODE_RESERVED_A = 8'hC3;
    localparam logic [7:0] CODE_RESERVED_B = 8'hC4;

    localparam int IDLE_PCT     = 21;
    localparam int RANDOM_WORDS = 1440;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 80;
    localparam int PAUSE_FROM   = 800;
    localparam int CALM_FROM    = 1000;
    localparam int CALM_TO      = 1200;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 1000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned words_in;
    int unsigned packets_done;
    int unsigned empty_packets;
    int unsigned payload_words;
    int unsigned header_errors;

    logic [7:0]  rx_stream[$];
    int          pause_at = -1;
    int          words_sent = 0;
    int          stall_cycles = 0;
    bit          calm = 1'b0;
    bit          holding = 1'b0;
    bit          hold_done = 1'b0;

    length_prefixed_packet_deframer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    length_prefixed_packet_deframer_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .mismatches    (mismatches),
        .pending       (pending),
        .words_in      (words_in),
        .packets_done  (packets_done),
        .empty_packets (empty_packets),
        .payload_words (payload_words),
        .header_errors (header_errors)
    );

    always #5 aclk = ~aclk;

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // code byte and total length of one packet
    task automatic queue_header(input bit long_fmt, input logic [15:0] total);
        if (long_fmt) begin
            rx_stream.push_back(CODE_LONG);
            rx_stream.push_back(total[15:8]);
        end else begin
            rx_stream.push_back(CODE_SHORT);
        end
        rx_stream.push_back(total[7:0]);
    endtask

    task automatic queue_packet(input bit long_fmt, input int unsigned n_payload);
        logic [15:0] total;
        total = 16'(n_payload) + (long_fmt ? HDR_LONG : HDR_SHORT);
        queue_header(long_fmt, total);
        repeat (n_payload) rx_stream.push_back(8'($urandom_range(255)));
    endtask

    // build the whole received stream up front
    task automatic build_stream();
        bit         long_fmt;
        int         roll;
        logic [7:0] b;

        // empty packets in both formats
        queue_header(1'b0, HDR_SHORT);
        queue_header(1'b1, HDR_LONG);
        // single-word packet, then payload extremes
        queue_header(1'b0, 16'd3);
        rx_stream.push_back(8'h00);
        queue_header(1'b0, 16'd4);
        rx_stream.push_back(8'hFF);
        rx_stream.push_back(8'h80);
        queue_header(1'b1, 16'd5);
        rx_stream.push_back(8'hFF);
        rx_stream.push_back(8'h00);
        queue_header(1'b0, 16'd5);
        rx_stream.push_back(8'h55);
        rx_stream.push_back(8'hAA);
        rx_stream.push_back(8'h01);

        // longest short-format packet and a long one with a nonzero high length byte
        queue_packet(1'b0, 253);
        queue_packet(1'b1, 257 + $urandom_range(40));

        // random well-formed packets, mostly small
        while (rx_stream.size() < RANDOM_WORDS) begin
            if (pause_at < 0 && rx_stream.size() >= PAUSE_FROM) pause_at = rx_stream.size();
            long_fmt = 1'($urandom_range(1));
            roll     = $urandom_range(99);
            if (roll < 8)
                queue_packet(long_fmt, 0);
            else if (roll < 10)
                queue_packet(long_fmt, long_fmt ? $urandom_range(300, 253)
                                                : $urandom_range(253, 200));
            else
                queue_packet(long_fmt, $urandom_range(16, 1));
        end

        // broken header at the end, it latches until reset
        case ($urandom_range(2))
            0: begin
                case ($urandom_range(3))
                    0: b = CODE_RESERVED_A;
                    1: b = CODE_RESERVED_B;
                    default: begin
                        do b = 8'($urandom_range(255));
                        while (b == CODE_SHORT || b == CODE_LONG);
                    end
                endcase
                rx_stream.push_back(b);
            end
            1: queue_header(1'b0, 16'($urandom_range(1)));
            default: queue_header(1'b1, 16'($urandom_range(2)));
        endcase
        // words after the error are dropped by the block
        rx_stream.push_back(CODE_SHORT);
        rx_stream.push_back(8'd5);
        repeat (6) rx_stream.push_back(8'($urandom_range(255)));
    endtask

    // result side: random back-pressure, one long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && words_sent >= HOLD_AT) begin
                holding   = 1'b1;
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                holding = 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // reset, stimulus and verdict
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        build_stream();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < rx_stream.size(); i++) begin
            // let everything drain once before going on
            if (i == pause_at) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            calm = (i >= CALM_FROM && i < CALM_TO);
            while (!calm && !holding && $urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= rx_stream[i];
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            words_sent++;
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d input words: %0d packets, %0d of them empty, %0d payload words",
                 words_in, packets_done, empty_packets, payload_words);
        $display("latched header errors seen: %0d, mismatches: %0d", header_errors, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
